### rtl/core/tst_pkg.sv
`timescale 1ns / 1ps
// Package of the top-k successor table: sizes, exponent factors, codes and
// the command and status bundles between controller and datapath. No dependencies.
package tst_pkg;

	localparam int VOCAB     = 4096;
	localparam int K_MAX     = 8;
	localparam int MAX_DRAFT = 16;

	localparam int TOK_W    = 12;
	localparam int CNT_W    = 13;
	localparam int LOGIT_W  = 16;
	localparam int SCORE_W  = 16;
	localparam int KCNT_W   = 4;
	localparam int KIDX_W   = 3;
	localparam int DLEN_W   = 5;
	localparam int FILL_W   = 4;
	localparam int ENT_W    = TOK_W + SCORE_W;
	localparam int ROW_W    = FILL_W + K_MAX * ENT_W;
	localparam int CFG_A_W  = 2;
	localparam int CFG_D_W  = 16;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 16;

	localparam int EXP_STAGES = 12;
	localparam int ACC_W      = 25;
	localparam int FAC_W      = 24;
	localparam int E_W        = 17;
	localparam int SUM_W      = 32;
	localparam int REM_W      = 34;
	localparam int QUO_W      = 18;
	localparam int BIT_W      = 5;

	localparam logic [FAC_W-1:0] EXP_FAC [EXP_STAGES] = '{
		24'd16711808, 24'd16646655, 24'd16517109, 24'd16261035,
		24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896,
		24'd6171993,  24'd2270549,  24'd307285,   24'd5628
	};

	localparam logic [CFG_A_W-1:0] CFG_VOCAB = 2'd0;
	localparam logic [CFG_A_W-1:0] CFG_TOPK  = 2'd1;
	localparam logic [CFG_A_W-1:0] CFG_DECAY = 2'd2;
	localparam logic [CFG_A_W-1:0] CFG_MIN   = 2'd3;

	typedef enum logic [1:0] {
		RS_DONE  = 2'd0,
		RS_IGN   = 2'd1,
		RS_DRAFT = 2'd2
	} res_t;

	typedef enum logic [1:0] {
		EM_UPD_DONE,
		EM_UPD_IGN,
		EM_DR_NONE,
		EM_DR_TOK
	} em_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_SUM,
		S_ROW_RD,
		S_ROW_LD,
		S_CAND,
		S_CAND_WAIT,
		S_DIV,
		S_APPLY,
		S_SORT,
		S_WB,
		S_DONE,
		S_IGNORE,
		S_DR_CHK,
		S_DR_WAIT,
		S_DR_FIN
	} state_t;

	typedef struct packed {
		logic clr;
		logic ready;
		logic scan;
		logic sum;
		logic row_rd;
		logic row_ld;
		logic cand_go;
		logic cand_wait;
		logic div;
		logic apply;
		logic sort;
		logic wb;
		logic dr_rd;
		logic dr_adv;
		logic emit;
		em_t  em;
		logic em_last;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_valid;
		logic in_kind;
		logic last_logit;
		logic ctx_ok;
		logic scan_done;
		logic sum_done;
		logic e_valid;
		logic div_last;
		logic cand_last;
		logic out_free;
		logic dr_end;
		logic dr_stop;
		logic dr_pend;
	} sts_t;

endpackage

### rtl/core/tst_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module tst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/tst_exp.sv
`timescale 1ns / 1ps
// Pipelined fixed-point exp(-d/256) in Q16, one multiply per stage.
// Depends on tst_pkg.
module tst_exp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [15:0]               in_d,
	output logic                      out_valid,
	output logic [tst_pkg::E_W-1:0]   out_e,
	output logic                      busy
);

	logic [tst_pkg::ACC_W-1:0] acc_s [tst_pkg::EXP_STAGES+1];
	logic [tst_pkg::EXP_STAGES-1:0] d_s [tst_pkg::EXP_STAGES+1];
	logic z_s [tst_pkg::EXP_STAGES+1];
	logic [tst_pkg::EXP_STAGES:0] v_s;
	logic out_valid_q;
	logic [tst_pkg::E_W-1:0] out_e_q;
	logic [tst_pkg::ACC_W:0] rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s <= {v_s[tst_pkg::EXP_STAGES-1:0], in_valid};
			out_valid_q <= v_s[tst_pkg::EXP_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		acc_s[0] <= tst_pkg::ACC_W'(1) << 24;
		d_s[0] <= in_d[tst_pkg::EXP_STAGES-1:0];
		z_s[0] <= |in_d[15:tst_pkg::EXP_STAGES];
	end

	for (genvar j = 0; j < tst_pkg::EXP_STAGES; j++) begin : g_stage
		logic [tst_pkg::ACC_W+tst_pkg::FAC_W-1:0] prod;
		assign prod = (tst_pkg::ACC_W+tst_pkg::FAC_W)'(acc_s[j]) * tst_pkg::EXP_FAC[j]
			+ (tst_pkg::ACC_W+tst_pkg::FAC_W)'(1 << 23);
		always_ff @(posedge clk) begin
			acc_s[j+1] <= d_s[j][j] ? prod[tst_pkg::ACC_W+23:24] : acc_s[j];
			d_s[j+1] <= d_s[j];
			z_s[j+1] <= z_s[j];
		end
	end

	assign rnd = {1'b0, acc_s[tst_pkg::EXP_STAGES]} + (tst_pkg::ACC_W+1)'(128);

	always_ff @(posedge clk) begin
		out_e_q <= z_s[tst_pkg::EXP_STAGES] ? '0 : rnd[tst_pkg::ACC_W-1:8];
	end

	assign out_valid = out_valid_q;
	assign out_e = out_e_q;
	assign busy = (|v_s) | out_valid_q;

endmodule

### rtl/core/tst_ctrl.sv
`timescale 1ns / 1ps
// Controller of the successor table: sequences row clearing, update passes,
// candidate scoring and draft walks. Depends on tst_pkg.
module tst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  tst_pkg::sts_t sts,
	output tst_pkg::cmd_t cmd
);

	tst_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tst_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			tst_pkg::S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = tst_pkg::S_IDLE;
			end
			tst_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				if (sts.in_valid) begin
					if (sts.in_kind) begin
						state_d = tst_pkg::S_DR_CHK;
					end else if (sts.last_logit) begin
						state_d = sts.ctx_ok ? tst_pkg::S_SCAN : tst_pkg::S_IGNORE;
					end
				end
			end
			tst_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = tst_pkg::S_SUM;
			end
			tst_pkg::S_SUM: begin
				cmd.sum = 1'b1;
				if (sts.sum_done) state_d = tst_pkg::S_ROW_RD;
			end
			tst_pkg::S_ROW_RD: begin
				cmd.row_rd = 1'b1;
				state_d = tst_pkg::S_ROW_LD;
			end
			tst_pkg::S_ROW_LD: begin
				cmd.row_ld = 1'b1;
				state_d = tst_pkg::S_CAND;
			end
			tst_pkg::S_CAND: begin
				cmd.cand_go = 1'b1;
				state_d = tst_pkg::S_CAND_WAIT;
			end
			tst_pkg::S_CAND_WAIT: begin
				cmd.cand_wait = 1'b1;
				if (sts.e_valid) state_d = tst_pkg::S_DIV;
			end
			tst_pkg::S_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_last) state_d = tst_pkg::S_APPLY;
			end
			tst_pkg::S_APPLY: begin
				cmd.apply = 1'b1;
				state_d = sts.cand_last ? tst_pkg::S_SORT : tst_pkg::S_CAND;
			end
			tst_pkg::S_SORT: begin
				cmd.sort = 1'b1;
				state_d = tst_pkg::S_WB;
			end
			tst_pkg::S_WB: begin
				cmd.wb = 1'b1;
				state_d = tst_pkg::S_DONE;
			end
			tst_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.em = tst_pkg::EM_UPD_DONE;
					cmd.em_last = 1'b1;
					state_d = tst_pkg::S_IDLE;
				end
			end
			tst_pkg::S_IGNORE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.em = tst_pkg::EM_UPD_IGN;
					cmd.em_last = 1'b1;
					state_d = tst_pkg::S_IDLE;
				end
			end
			tst_pkg::S_DR_CHK: begin
				if (sts.dr_end) begin
					state_d = tst_pkg::S_DR_FIN;
				end else begin
					cmd.dr_rd = 1'b1;
					state_d = tst_pkg::S_DR_WAIT;
				end
			end
			tst_pkg::S_DR_WAIT: begin
				if (sts.dr_stop) begin
					state_d = tst_pkg::S_DR_FIN;
				end else if (!sts.dr_pend || sts.out_free) begin
					cmd.dr_adv = 1'b1;
					cmd.emit = sts.dr_pend;
					cmd.em = tst_pkg::EM_DR_TOK;
					state_d = tst_pkg::S_DR_CHK;
				end
			end
			tst_pkg::S_DR_FIN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.em = sts.dr_pend ? tst_pkg::EM_DR_TOK : tst_pkg::EM_DR_NONE;
					cmd.em_last = 1'b1;
					state_d = tst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tst_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/tst_datapath.sv
`timescale 1ns / 1ps
// Datapath of the successor table: configuration, logit and row memories,
// top-k insertion, exp sum, divider, row update and sort, draft walk, output.
// Depends on tst_pkg, tst_ram and tst_exp.
module tst_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tst_pkg::CFG_A_W-1:0]   cfg_addr,
	input  logic [tst_pkg::CFG_D_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	input  logic [tst_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tst_pkg::M_DATA_W-1:0]  m_tdata,
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast,
	input  tst_pkg::cmd_t                 cmd,
	output tst_pkg::sts_t                 sts
);

	localparam int TW = tst_pkg::TOK_W;
	localparam int SW = tst_pkg::SCORE_W;
	localparam int KM = tst_pkg::K_MAX;

	logic [tst_pkg::CNT_W-1:0] vocab_q;
	logic [tst_pkg::KCNT_W-1:0] topk_q;
	logic [SW-1:0] decay_q;
	logic [SW-1:0] minsc_q;
	logic [tst_pkg::CNT_W-1:0] v_eff;
	logic [tst_pkg::KCNT_W-1:0] k_eff;

	logic take;
	logic [TW-1:0] in_ctx;
	logic [tst_pkg::LOGIT_W-1:0] in_logit;
	logic [tst_pkg::DLEN_W-1:0] in_dlen;
	logic [tst_pkg::CNT_W-1:0] cnt_inc;

	logic [tst_pkg::CNT_W-1:0] logit_cnt_q;
	logic [tst_pkg::CNT_W-1:0] idx_q;
	logic rd_v_s1;
	logic [TW-1:0] tokidx_s1;
	logic [TW-1:0] ctx_q;
	logic [TW-1:0] clr_q;

	logic lram_re;
	logic [tst_pkg::LOGIT_W-1:0] lram_rdata;

	logic signed [tst_pkg::LOGIT_W-1:0] best_logit_q [KM];
	logic [TW-1:0] best_tok_q [KM];
	logic [tst_pkg::KCNT_W-1:0] n_q;
	logic [tst_pkg::KIDX_W-1:0] cand_q;

	logic signed [tst_pkg::LOGIT_W-1:0] l_sc;
	logic [KM-1:0] ge_v;
	logic [tst_pkg::KCNT_W-1:0] pos;
	logic [tst_pkg::KCNT_W-1:0] lim;
	logic ins;

	logic exp_in_v;
	logic [15:0] exp_d;
	logic signed [tst_pkg::LOGIT_W:0] diff;
	logic exp_out_v;
	logic [tst_pkg::E_W-1:0] exp_e;
	logic exp_busy;

	logic [tst_pkg::SUM_W-1:0] sum_q;
	logic [tst_pkg::SUM_W:0] sum_add;
	logic [tst_pkg::REM_W-1:0] rem_q;
	logic [tst_pkg::QUO_W-1:0] quo_q;
	logic [tst_pkg::BIT_W-1:0] bit_q;
	logic [tst_pkg::REM_W+tst_pkg::QUO_W-1:0] div_sh;
	logic div_ge;
	logic [SW-1:0] prob;

	logic [TW-1:0] row_tok_q [KM];
	logic [SW-1:0] row_sc_q [KM];
	logic [tst_pkg::FILL_W-1:0] row_fill_q;
	logic row_we;
	logic row_re;
	logic [TW-1:0] row_waddr;
	logic [TW-1:0] row_raddr;
	logic [tst_pkg::ROW_W-1:0] row_wdata;
	logic [tst_pkg::ROW_W-1:0] row_pack;
	logic [tst_pkg::ROW_W-1:0] row_rdata;

	logic [TW-1:0] c_tok;
	logic hit;
	logic [tst_pkg::KIDX_W-1:0] hit_idx;
	logic [tst_pkg::KIDX_W-1:0] min_idx;
	logic [SW-1:0] b_old;
	logic [31:0] prod1;
	logic [32:0] prod2;
	logic [tst_pkg::E_W-1:0] w_new;
	logic [33:0] bsum;
	logic [SW-1:0] blend;

	logic [tst_pkg::KCNT_W-1:0] rank [KM];
	logic [TW-1:0] srt_tok [KM];
	logic [SW-1:0] srt_sc [KM];

	logic [TW-1:0] cur_q;
	logic [tst_pkg::DLEN_W-1:0] dlen_q;
	logic [tst_pkg::DLEN_W-1:0] steps_q;
	logic pend_q;
	logic [TW-1:0] pend_tok_q;
	logic [tst_pkg::FILL_W-1:0] dr_fill;
	logic [TW-1:0] dr_tok;
	logic [SW-1:0] dr_sc;

	logic out_valid_q;
	tst_pkg::res_t out_status_q;
	logic [TW-1:0] out_tok_q;
	logic out_tv_q;
	logic out_last_q;
	logic out_free;

	// Configuration registers and their clamped forms.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_q <= tst_pkg::CNT_W'(tst_pkg::VOCAB);
			topk_q <= tst_pkg::KCNT_W'(KM);
			decay_q <= '0;
			minsc_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				tst_pkg::CFG_VOCAB: vocab_q <= cfg_data[tst_pkg::CNT_W-1:0];
				tst_pkg::CFG_TOPK:  topk_q <= cfg_data[tst_pkg::KCNT_W-1:0];
				tst_pkg::CFG_DECAY: decay_q <= cfg_data;
				tst_pkg::CFG_MIN:   minsc_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (vocab_q < tst_pkg::CNT_W'(2)) v_eff = tst_pkg::CNT_W'(2);
		else if (vocab_q > tst_pkg::CNT_W'(tst_pkg::VOCAB)) v_eff = tst_pkg::CNT_W'(tst_pkg::VOCAB);
		else v_eff = vocab_q;
		if (topk_q == '0) k_eff = tst_pkg::KCNT_W'(1);
		else if (topk_q > tst_pkg::KCNT_W'(KM)) k_eff = tst_pkg::KCNT_W'(KM);
		else k_eff = topk_q;
		if (tst_pkg::CNT_W'(k_eff) > v_eff) k_eff = v_eff[tst_pkg::KCNT_W-1:0];
	end

	// Input beat fields.
	assign take = cmd.ready & s_tvalid;
	assign in_ctx = s_tdata[TW-1:0];
	assign in_logit = s_tdata[TW +: tst_pkg::LOGIT_W];
	assign in_dlen = s_tdata[TW+tst_pkg::LOGIT_W +: tst_pkg::DLEN_W];
	assign cnt_inc = logit_cnt_q + tst_pkg::CNT_W'(1);

	assign lram_re = (cmd.scan | cmd.sum) && (idx_q < v_eff);

	tst_ram #(
		.WIDTH(tst_pkg::LOGIT_W),
		.DEPTH(tst_pkg::VOCAB)
	) u_logit_ram (
		.clk  (clk),
		.we   (take & ~s_tuser),
		.waddr(logit_cnt_q[TW-1:0]),
		.wdata(in_logit),
		.re   (lram_re),
		.raddr(idx_q[TW-1:0]),
		.rdata(lram_rdata)
	);

	// Top-k insertion of one streamed logit.
	always_comb begin
		l_sc = $signed(lram_rdata);
		for (int j = 0; j < KM; j++) begin
			ge_v[j] = (tst_pkg::KCNT_W'(j) < n_q) && (best_logit_q[j] >= l_sc);
		end
		pos = tst_pkg::KCNT_W'($countones(ge_v));
		lim = (n_q < k_eff) ? n_q : k_eff - tst_pkg::KCNT_W'(1);
		ins = !((n_q == k_eff) && (pos == k_eff));
	end

	// Exponent pipe input, shared by the sum pass and candidate scoring.
	always_comb begin
		if (cmd.sum) begin
			diff = {best_logit_q[0][tst_pkg::LOGIT_W-1], best_logit_q[0]}
				- {l_sc[tst_pkg::LOGIT_W-1], l_sc};
			exp_in_v = rd_v_s1;
		end else begin
			diff = {best_logit_q[0][tst_pkg::LOGIT_W-1], best_logit_q[0]}
				- {best_logit_q[cand_q][tst_pkg::LOGIT_W-1], best_logit_q[cand_q]};
			exp_in_v = cmd.cand_go;
		end
		exp_d = diff[15:0];
	end

	tst_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (exp_in_v),
		.in_d     (exp_d),
		.out_valid(exp_out_v),
		.out_e    (exp_e),
		.busy     (exp_busy)
	);

	assign sum_add = {1'b0, sum_q} + (tst_pkg::SUM_W+1)'(exp_e);

	// Restoring divider step.
	assign div_sh = (tst_pkg::REM_W+tst_pkg::QUO_W)'(sum_q) << bit_q;
	assign div_ge = (tst_pkg::REM_W+tst_pkg::QUO_W)'(rem_q) >= div_sh;
	assign prob = (|quo_q[tst_pkg::QUO_W-1:SW]) ? '1 : quo_q[SW-1:0];

	// Candidate against the row: hit search, first minimum and blend.
	always_comb begin
		c_tok = best_tok_q[cand_q];
		hit = 1'b0;
		hit_idx = '0;
		for (int j = KM - 1; j >= 0; j--) begin
			if ((tst_pkg::FILL_W'(j) < row_fill_q) && (row_tok_q[j] == c_tok)) begin
				hit = 1'b1;
				hit_idx = tst_pkg::KIDX_W'(j);
			end
		end
		min_idx = '0;
		for (int j = 1; j < KM; j++) begin
			if ((tst_pkg::FILL_W'(j) < row_fill_q) && (row_sc_q[j] < row_sc_q[min_idx])) begin
				min_idx = tst_pkg::KIDX_W'(j);
			end
		end
		b_old = hit ? row_sc_q[hit_idx] : row_sc_q[min_idx];
		w_new = tst_pkg::E_W'(1 << 16) - tst_pkg::E_W'(decay_q);
		prod1 = 32'(decay_q) * 32'(b_old);
		prod2 = 33'(w_new) * 33'(prob);
		bsum = 34'(prod1) + 34'(prod2) + 34'(1 << 15);
		blend = bsum[31:16];
	end

	// Stable descending ranks of the row entries.
	always_comb begin
		for (int i = 0; i < KM; i++) begin
			rank[i] = '0;
			for (int j = 0; j < KM; j++) begin
				if ((tst_pkg::FILL_W'(j) < row_fill_q) && ((row_sc_q[j] > row_sc_q[i])
						|| ((row_sc_q[j] == row_sc_q[i]) && (j < i)))) begin
					rank[i] = rank[i] + tst_pkg::KCNT_W'(1);
				end
			end
		end
		for (int i = 0; i < KM; i++) begin
			srt_tok[i] = row_tok_q[i];
			srt_sc[i] = row_sc_q[i];
		end
		for (int i = 0; i < KM; i++) begin
			if (tst_pkg::FILL_W'(i) < row_fill_q) begin
				srt_tok[rank[i][tst_pkg::KIDX_W-1:0]] = row_tok_q[i];
				srt_sc[rank[i][tst_pkg::KIDX_W-1:0]] = row_sc_q[i];
			end
		end
	end

	// Row memory: one word per context token holding fill and all entries.
	always_comb begin
		row_pack = '0;
		row_pack[tst_pkg::FILL_W-1:0] = row_fill_q;
		for (int j = 0; j < KM; j++) begin
			row_pack[tst_pkg::FILL_W + j*tst_pkg::ENT_W +: TW] = row_tok_q[j];
			row_pack[tst_pkg::FILL_W + j*tst_pkg::ENT_W + TW +: SW] = row_sc_q[j];
		end
	end

	assign row_we = cmd.clr | cmd.wb;
	assign row_waddr = cmd.clr ? clr_q : ctx_q;
	assign row_wdata = cmd.clr ? '0 : row_pack;
	assign row_re = cmd.row_rd | cmd.dr_rd;
	assign row_raddr = cmd.dr_rd ? cur_q : ctx_q;

	tst_ram #(
		.WIDTH(tst_pkg::ROW_W),
		.DEPTH(tst_pkg::VOCAB)
	) u_row_ram (
		.clk  (clk),
		.we   (row_we),
		.waddr(row_waddr),
		.wdata(row_wdata),
		.re   (row_re),
		.raddr(row_raddr),
		.rdata(row_rdata)
	);

	assign dr_fill = row_rdata[tst_pkg::FILL_W-1:0];
	assign dr_tok = row_rdata[tst_pkg::FILL_W +: TW];
	assign dr_sc = row_rdata[tst_pkg::FILL_W + TW +: SW];

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			logit_cnt_q <= '0;
			idx_q <= '0;
			rd_v_s1 <= 1'b0;
			n_q <= '0;
			cand_q <= '0;
			bit_q <= '0;
			steps_q <= '0;
			dlen_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + TW'(1);
			rd_v_s1 <= lram_re;
			if (lram_re) idx_q <= idx_q + tst_pkg::CNT_W'(1);
			if (take) begin
				idx_q <= '0;
				if (!s_tuser) begin
					logit_cnt_q <= (cnt_inc >= v_eff) ? '0 : cnt_inc;
					n_q <= '0;
				end else begin
					dlen_q <= (in_dlen > tst_pkg::DLEN_W'(tst_pkg::MAX_DRAFT))
						? tst_pkg::DLEN_W'(tst_pkg::MAX_DRAFT) : in_dlen;
					steps_q <= '0;
					pend_q <= 1'b0;
				end
			end
			if (cmd.scan && rd_v_s1 && ins && (n_q < k_eff)) n_q <= n_q + tst_pkg::KCNT_W'(1);
			if (cmd.scan && sts.scan_done) idx_q <= '0;
			if (cmd.row_ld) cand_q <= '0;
			if (cmd.apply) cand_q <= cand_q + tst_pkg::KIDX_W'(1);
			if (cmd.cand_wait && exp_out_v) bit_q <= tst_pkg::BIT_W'(tst_pkg::QUO_W - 1);
			if (cmd.div && bit_q != '0) bit_q <= bit_q - tst_pkg::BIT_W'(1);
			if (cmd.dr_adv) begin
				pend_q <= 1'b1;
				steps_q <= steps_q + tst_pkg::DLEN_W'(1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take) begin
			if (!s_tuser) ctx_q <= in_ctx;
			else cur_q <= in_ctx;
		end
		tokidx_s1 <= idx_q[TW-1:0];
		if (cmd.scan && rd_v_s1 && ins) begin
			for (int j = 1; j < KM; j++) begin
				if ((tst_pkg::KCNT_W'(j) > pos) && (tst_pkg::KCNT_W'(j) <= lim)) begin
					best_logit_q[j] <= best_logit_q[j-1];
					best_tok_q[j] <= best_tok_q[j-1];
				end
			end
			for (int j = 0; j < KM; j++) begin
				if (tst_pkg::KCNT_W'(j) == pos) begin
					best_logit_q[j] <= l_sc;
					best_tok_q[j] <= tokidx_s1;
				end
			end
		end
		if (cmd.scan && sts.scan_done) sum_q <= '0;
		if (cmd.sum && exp_out_v) sum_q <= sum_add[tst_pkg::SUM_W] ? '1 : sum_add[tst_pkg::SUM_W-1:0];
		if (cmd.cand_wait && exp_out_v) begin
			rem_q <= tst_pkg::REM_W'({exp_e, 16'd0}) + tst_pkg::REM_W'(sum_q[tst_pkg::SUM_W-1:1]);
			quo_q <= '0;
		end
		if (cmd.div && div_ge) begin
			rem_q <= rem_q - div_sh[tst_pkg::REM_W-1:0];
			quo_q <= quo_q | (tst_pkg::QUO_W'(1) << bit_q);
		end
		if (cmd.row_ld) begin
			row_fill_q <= row_rdata[tst_pkg::FILL_W-1:0];
			for (int j = 0; j < KM; j++) begin
				row_tok_q[j] <= row_rdata[tst_pkg::FILL_W + j*tst_pkg::ENT_W +: TW];
				row_sc_q[j] <= row_rdata[tst_pkg::FILL_W + j*tst_pkg::ENT_W + TW +: SW];
			end
		end
		if (cmd.apply) begin
			if (hit) begin
				row_sc_q[hit_idx] <= blend;
			end else if (row_fill_q < k_eff) begin
				row_tok_q[row_fill_q[tst_pkg::KIDX_W-1:0]] <= c_tok;
				row_sc_q[row_fill_q[tst_pkg::KIDX_W-1:0]] <= prob;
				row_fill_q <= row_fill_q + tst_pkg::FILL_W'(1);
			end else if (prob > row_sc_q[min_idx]) begin
				row_tok_q[min_idx] <= c_tok;
				row_sc_q[min_idx] <= blend;
			end
		end
		if (cmd.sort) begin
			for (int j = 0; j < KM; j++) begin
				row_tok_q[j] <= srt_tok[j];
				row_sc_q[j] <= srt_sc[j];
			end
		end
		if (cmd.dr_adv) begin
			pend_tok_q <= dr_tok;
			cur_q <= dr_tok;
		end
	end

	// Output register.
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_last_q <= cmd.em_last;
			case (cmd.em)
				tst_pkg::EM_UPD_DONE: begin
					out_status_q <= tst_pkg::RS_DONE;
					out_tok_q <= '0;
					out_tv_q <= 1'b0;
				end
				tst_pkg::EM_UPD_IGN: begin
					out_status_q <= tst_pkg::RS_IGN;
					out_tok_q <= '0;
					out_tv_q <= 1'b0;
				end
				tst_pkg::EM_DR_TOK: begin
					out_status_q <= tst_pkg::RS_DRAFT;
					out_tok_q <= pend_tok_q;
					out_tv_q <= 1'b1;
				end
				default: begin
					out_status_q <= tst_pkg::RS_DRAFT;
					out_tok_q <= '0;
					out_tv_q <= 1'b0;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = tst_pkg::M_DATA_W'({out_tv_q, out_tok_q});
	assign m_tuser = out_status_q;
	assign m_tlast = out_last_q;

	// Status towards the controller.
	always_comb begin
		sts = '0;
		sts.clr_last = (clr_q == TW'(tst_pkg::VOCAB - 1));
		sts.in_valid = s_tvalid;
		sts.in_kind = s_tuser;
		sts.last_logit = (cnt_inc >= v_eff);
		sts.ctx_ok = (tst_pkg::CNT_W'(in_ctx) < v_eff);
		sts.scan_done = (idx_q >= v_eff) && !rd_v_s1;
		sts.sum_done = (idx_q >= v_eff) && !rd_v_s1 && !exp_busy;
		sts.e_valid = exp_out_v;
		sts.div_last = (bit_q == '0);
		sts.cand_last = (tst_pkg::KCNT_W'(cand_q) == n_q - tst_pkg::KCNT_W'(1));
		sts.out_free = out_free;
		sts.dr_end = (steps_q == dlen_q) || (tst_pkg::CNT_W'(cur_q) >= v_eff);
		sts.dr_stop = (dr_fill == '0) || ((minsc_q != '0) && (dr_sc < minsc_q));
		sts.dr_pend = pend_q;
	end

endmodule

### rtl/core/topk_successor_table_core.sv
`timescale 1ns / 1ps
// Top level of the top-k successor table: controller and datapath.
// Depends on tst_pkg, tst_ctrl and tst_datapath.
//
// The input stream carries update logits (tuser 0) in token index order and
// draft requests (tuser 1). A logit beat is taken every cycle while the
// block is idle and gives no result until the last logit of an update, which
// starts the update pass: a top-k scan of the stored logits, an exp sum
// through a 14-stage exponent pipe, then for each candidate its exp and an
// 18-step divider, and at last a sort and write-back of the row. One status
// beat (tlast set) closes each update. A draft request walks the row memory
// token by token and returns one beat per token, the final one with tlast
// set, or a single beat without a token if no token is drafted. Input is
// taken only while the block is idle.
// After reset the block sweeps the 4096 rows of the row memory, one a cycle,
// clearing their fill counts, and accepts no beat before that is finished;
// configuration writes are taken throughout. A stalled receiver holds the
// result in the output register and the block waits before the next result.
module topk_successor_table_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tst_pkg::CFG_A_W-1:0]   cfg_addr,
	input  logic [tst_pkg::CFG_D_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tst_pkg::S_DATA_W-1:0]  s_tdata,  // context_token, logit, draft_length
	input  logic                          s_tuser,  // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tst_pkg::M_DATA_W-1:0]  m_tdata,  // token, token_valid
	output logic [1:0]                    m_tuser,  // status
	output logic                          m_tlast
);

	tst_pkg::cmd_t cmd;
	tst_pkg::sts_t sts;

	tst_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	tst_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.cmd     (cmd),
		.sts     (sts)
	);

	assign s_tready = cmd.ready;

endmodule

### test/topk_successor_table_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of topk_successor_table_core: streams update logits and draft
// requests, predicts every status and draft beat and checks them. Depends on tst_pkg and topk_successor_table_core.
module topk_successor_table_core_test;

	localparam int IDLE_LIMIT = 60000;

	typedef struct {
		tst_pkg::res_t status;
		logic [11:0]   token;
		logic          token_valid;
		logic          last;
	} result_t;

	class successor_scoreboard;
		logic [12:0] vocab_reg;
		logic [3:0]  topk_reg;
		logic [15:0] decay_reg;
		logic [15:0] min_reg;
		logic [15:0] logit_mem [tst_pkg::VOCAB];
		logic [11:0] row_tok [tst_pkg::VOCAB*tst_pkg::K_MAX];
		logic [15:0] row_sc [tst_pkg::VOCAB*tst_pkg::K_MAX];
		int unsigned row_cnt [tst_pkg::VOCAB];
		int unsigned logit_idx;
		result_t     expected_q [$];
		int          errors;

		function new();
			vocab_reg = 13'd4096;
			topk_reg  = 4'd8;
			decay_reg = '0;
			min_reg   = '0;
			logit_idx = 0;
			errors    = 0;
			foreach (row_cnt[i]) row_cnt[i] = 0;
		endfunction

		function void write_reg(logic [tst_pkg::CFG_A_W-1:0] idx,
				logic [tst_pkg::CFG_D_W-1:0] val);
			case (idx)
				tst_pkg::CFG_VOCAB: vocab_reg = val[12:0];
				tst_pkg::CFG_TOPK:  topk_reg  = val[3:0];
				tst_pkg::CFG_DECAY: decay_reg = val;
				tst_pkg::CFG_MIN:   min_reg   = val;
				default: begin
				end
			endcase
		endfunction

		function int unsigned vocab_now();
			int unsigned v;
			v = vocab_reg;
			if (v < 2) v = 2;
			if (v > tst_pkg::VOCAB) v = tst_pkg::VOCAB;
			return v;
		endfunction

		function int unsigned exp_q16(int unsigned d);
			longint unsigned acc;
			acc = 64'd16777216;
			if (d >= 4096) return 0;
			for (int j = 0; j < tst_pkg::EXP_STAGES; j++)
				if (d[j]) acc = (acc * tst_pkg::EXP_FAC[j] + 64'd8388608) >> 24;
			return 32'((acc + 128) >> 8);
		endfunction

		function logic [15:0] blend(logic [15:0] old, int unsigned prob);
			longint unsigned s;
			s = longint'(decay_reg) * old + longint'(65536 - decay_reg) * prob + 32768;
			return s[31:16];
		endfunction

		function void update_row(int unsigned ctx, int unsigned v);
			int unsigned k, n, fill, base, pos, m, sum, prob, j;
			int mx, l;
			int best_l [tst_pkg::K_MAX];
			logic [11:0] best_t [tst_pkg::K_MAX];
			longint unsigned acc, p;
			logic [11:0] t;
			logic [15:0] s;
			bit hit;
			k = topk_reg;
			if (k < 1) k = 1;
			if (k > tst_pkg::K_MAX) k = tst_pkg::K_MAX;
			if (k > v) k = v;
			mx = $signed(logit_mem[0]);
			for (int i = 1; i < v; i++) begin
				l = $signed(logit_mem[i]);
				if (l > mx) mx = l;
			end
			acc = 0;
			for (int i = 0; i < v; i++) begin
				acc += exp_q16(mx - $signed(logit_mem[i]));
				if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
			end
			sum = 32'(acc);
			n = 0;
			for (int i = 0; i < v; i++) begin
				l = $signed(logit_mem[i]);
				if (n == k && l <= best_l[k-1]) continue;
				pos = (n < k) ? n : k - 1;
				while (pos > 0 && best_l[pos-1] < l) begin
					best_l[pos] = best_l[pos-1];
					best_t[pos] = best_t[pos-1];
					pos--;
				end
				best_l[pos] = l;
				best_t[pos] = 12'(i);
				if (n < k) n++;
			end
			base = ctx * tst_pkg::K_MAX;
			fill = row_cnt[ctx];
			for (int i = 0; i < n; i++) begin
				p = (longint'(exp_q16(mx - best_l[i])) * 65536 + (sum >> 1)) / sum;
				prob = (p > 65535) ? 65535 : 32'(p);
				hit = 0;
				for (j = 0; j < fill; j++)
					if (row_tok[base+j] == best_t[i]) begin
						row_sc[base+j] = blend(row_sc[base+j], prob);
						hit = 1;
						break;
					end
				if (hit) continue;
				if (fill < k) begin
					row_tok[base+fill] = best_t[i];
					row_sc[base+fill]  = 16'(prob);
					fill++;
				end else begin
					m = 0;
					for (j = 1; j < fill; j++)
						if (row_sc[base+j] < row_sc[base+m]) m = j;
					if (prob > row_sc[base+m]) begin
						row_tok[base+m] = best_t[i];
						row_sc[base+m]  = blend(row_sc[base+m], prob);
					end
				end
			end
			row_cnt[ctx] = fill;
			for (int i = 1; i < fill; i++) begin
				t = row_tok[base+i];
				s = row_sc[base+i];
				j = i;
				while (j > 0 && row_sc[base+j-1] < s) begin
					row_tok[base+j] = row_tok[base+j-1];
					row_sc[base+j]  = row_sc[base+j-1];
					j--;
				end
				row_tok[base+j] = t;
				row_sc[base+j]  = s;
			end
		endfunction

		function void push(tst_pkg::res_t st, logic [11:0] tok, logic vld, logic lst);
			result_t r;
			r.status = st;
			r.token = tok;
			r.token_valid = vld;
			r.last = lst;
			expected_q = {expected_q, r};
		endfunction

		function void note_input(logic kind, logic [11:0] ctx, logic [15:0] lg, logic [4:0] dl);
			int unsigned v, n, cur, cnt;
			v = vocab_now();
			if (!kind) begin
				if (logit_idx < tst_pkg::VOCAB) logit_mem[logit_idx] = lg;
				logit_idx++;
				if (logit_idx < v) return;
				logit_idx = 0;
				if (ctx >= v) begin
					push(tst_pkg::RS_IGN, '0, 1'b0, 1'b1);
				end else begin
					update_row(ctx, v);
					push(tst_pkg::RS_DONE, '0, 1'b0, 1'b1);
				end
			end else begin
				n = (dl > tst_pkg::MAX_DRAFT) ? tst_pkg::MAX_DRAFT : dl;
				cur = ctx;
				cnt = 0;
				for (int i = 0; i < n; i++) begin
					if (cur >= v || row_cnt[cur] == 0) break;
					if (min_reg != 0 && row_sc[cur*tst_pkg::K_MAX] < min_reg) break;
					push(tst_pkg::RS_DRAFT, row_tok[cur*tst_pkg::K_MAX], 1'b1, 1'b0);
					cur = row_tok[cur*tst_pkg::K_MAX];
					cnt++;
				end
				if (cnt == 0) push(tst_pkg::RS_DRAFT, '0, 1'b0, 1'b1);
				else expected_q[$].last = 1'b1;
			end
		endfunction

		function void check_result(logic [1:0] st, logic [11:0] tok, logic vld, logic lst);
			result_t r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected beat status %0d token %0d valid %0b last %0b",
					$time, st, tok, vld, lst);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (st !== r.status) begin
				$display("%0t: status expected %0d actual %0d", $time, r.status, st);
				errors++;
			end
			if (tok !== r.token) begin
				$display("%0t: token expected %0d actual %0d", $time, r.token, tok);
				errors++;
			end
			if (vld !== r.token_valid) begin
				$display("%0t: token_valid expected %0b actual %0b", $time, r.token_valid, vld);
				errors++;
			end
			if (lst !== r.last) begin
				$display("%0t: last expected %0b actual %0b", $time, r.last, lst);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [tst_pkg::CFG_A_W-1:0]  cfg_addr;
	logic [tst_pkg::CFG_D_W-1:0]  cfg_data;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [tst_pkg::S_DATA_W-1:0] s_tdata;
	logic                         s_tuser;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [tst_pkg::M_DATA_W-1:0] m_tdata;
	logic [1:0]                   m_tuser;
	logic                         m_tlast;

	successor_scoreboard sb;
	bit calm;
	bit stall_req;
	int idle_cycles;

	topk_successor_table_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_beat(logic kind, logic [11:0] ctx, logic [15:0] lg, logic [4:0] dl);
		int gap;
		@(negedge clk);
		s_tuser  = kind;
		s_tdata  = {7'd0, dl, lg, ctx};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_input(kind, ctx, lg, dl);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic wait_idle();
		drain();
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic [tst_pkg::CFG_A_W-1:0] idx, logic [tst_pkg::CFG_D_W-1:0] val);
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_addr = idx;
		cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_phase(int v, int k, int d, int m);
		wait_idle();
		write_reg(tst_pkg::CFG_VOCAB, 16'(v));
		write_reg(tst_pkg::CFG_TOPK, 16'(k));
		write_reg(tst_pkg::CFG_DECAY, 16'(d));
		write_reg(tst_pkg::CFG_MIN, 16'(m));
	endtask

	task automatic send_draft();
		int unsigned v;
		logic [11:0] start;
		logic [4:0] len;
		v = sb.vocab_now();
		start = ($urandom_range(0, 9) < 8) ? 12'($urandom_range(0, v - 1))
			: 12'($urandom_range(0, 4095));
		len = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 16)) : 5'($urandom_range(0, 31));
		send_beat(1'b1, start, 16'($urandom), len);
	endtask

	task automatic send_update(int unsigned mode, int unsigned n_items);
		int unsigned v;
		int base;
		logic [11:0] ctx;
		logic [15:0] lg;
		v = sb.vocab_now();
		base = $urandom_range(0, 16000) - 8000;
		case ($urandom_range(0, 9))
			0:       ctx = 12'($urandom_range(0, 4095));
			1:       ctx = (v < 4096) ? 12'($urandom_range(v, 4095)) : 12'd0;
			default: ctx = 12'($urandom_range(0, v - 1));
		endcase
		for (int i = 0; i < n_items; i++) begin
			case (mode)
				0:       lg = 16'($urandom);
				1:       lg = 16'(base + $urandom_range(0, 1536) - 768);
				default: lg = ($urandom_range(0, 2) == 0) ? 16'hFF00 : 16'h0100;
			endcase
			if ($urandom_range(0, 19) == 0) send_draft();
			send_beat(1'b0, (i == n_items - 1) ? ctx : 12'($urandom), lg, 5'($urandom));
		end
	endtask

	task automatic random_phase(int budget, bit with_stall, bit with_pause);
		int unsigned v;
		v = sb.vocab_now();
		for (int done = 0; done < budget; ) begin
			if (with_stall && done == 0) stall_req = 1'b1;
			if (with_pause && done > budget / 2) begin
				drain();
				with_pause = 0;
			end
			if ($urandom_range(0, 9) < 3) begin
				send_draft();
				done++;
			end else begin
				send_update($urandom_range(0, 2), v);
				done += v;
			end
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				m_tready = 1'b0;
				repeat (400) @(negedge clk);
			end else if (calm || $urandom_range(0, 99) < 70) begin
				m_tready = 1'b1;
			end else begin
				m_tready = 1'b0;
				repeat (($urandom_range(0, 9) < 9) ? $urandom_range(0, 3)
					: $urandom_range(10, 50)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[11:0], m_tdata[12], m_tlast);
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		calm = 1'b0;
		stall_req = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Drafts from empty rows at the reset settings.
		send_beat(1'b1, 12'd4095, 16'h0000, 5'd3);
		send_beat(1'b1, 12'd0, 16'h0000, 5'd16);

		// Smallest vocabulary and one candidate.
		set_phase(2, 1, 0, 0);
		calm = 1'b1;
		send_beat(1'b1, 12'd0, 16'h0000, 5'd5);
		send_beat(1'b0, 12'hFFF, 16'h7FFF, 5'd31);
		send_beat(1'b0, 12'd0, 16'h8000, 5'd0);
		send_beat(1'b0, 12'd0, 16'h0100, 5'd0);
		send_beat(1'b0, 12'd1, 16'h0100, 5'd0);
		send_beat(1'b0, 12'd0, 16'h0000, 5'd0);
		send_beat(1'b1, 12'd7, 16'h0000, 5'd4);
		send_beat(1'b0, 12'd3, 16'h0200, 5'd0);
		send_beat(1'b0, 12'd1, 16'h0000, 5'd0);
		send_beat(1'b0, 12'd2, 16'h0000, 5'd0);
		send_beat(1'b0, 12'd1, 16'h0200, 5'd0);
		send_beat(1'b1, 12'd1, 16'h0000, 5'd16);
		send_beat(1'b1, 12'd1, 16'h0000, 5'd31);
		send_beat(1'b1, 12'd0, 16'h0000, 5'd0);
		send_beat(1'b1, 12'd2, 16'h0000, 5'd8);
		send_beat(1'b1, 12'hFFF, 16'h0000, 5'd8);
		calm = 1'b0;

		set_phase(16, 8, 0, 0);
		random_phase(70, 1, 0);
		set_phase(16, 3, 65535, 0);
		random_phase(60, 0, 1);
		set_phase(12, 4, 32768, 2000);
		calm = 1'b1;
		random_phase(50, 0, 0);
		calm = 1'b0;
		set_phase(2, 1, 40000, 65535);
		random_phase(40, 0, 0);
		set_phase(0, 15, 1000, 500);
		random_phase(40, 0, 0);
		set_phase(32, 0, 20000, 1);
		random_phase(80, 1, 0);
		set_phase(8, 8, 50000, 12000);
		random_phase(60, 0, 0);

		drain();
		repeat (200) @(negedge clk);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

### topk_successor_table_core.f
rtl/core/tst_pkg.sv
rtl/core/tst_ram.sv
rtl/core/tst_exp.sv
rtl/core/tst_ctrl.sv
rtl/core/tst_datapath.sv
rtl/core/topk_successor_table_core.sv
test/topk_successor_table_core_test.sv
